### rtl/obbsat_pkg.sv
`timescale 1ns / 1ps
package obbsat_pkg;

  localparam int unsigned CoordW      = 32;
  localparam int unsigned RadW        = 31;
  localparam int unsigned NrmW        = 18;
  localparam int unsigned DepthW      = 32;
  localparam int unsigned FracBitsDef = 16;

  localparam int unsigned MulAW = 36;
  localparam int unsigned MulBW = 31;
  localparam int unsigned MulPW = MulAW + MulBW;

endpackage

### rtl/obbsat_if.sv
`timescale 1ns / 1ps
interface obbsat_req_if;
  import obbsat_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [CoordW-1:0] corner0_x;
  logic signed [CoordW-1:0] corner0_y;
  logic signed [CoordW-1:0] corner1_x;
  logic signed [CoordW-1:0] corner1_y;
  logic signed [CoordW-1:0] corner2_x;
  logic signed [CoordW-1:0] corner2_y;
  logic signed [CoordW-1:0] corner3_x;
  logic signed [CoordW-1:0] corner3_y;
  logic signed [CoordW-1:0] circle_left;
  logic signed [CoordW-1:0] circle_top;
  logic        [RadW-1:0]   circle_radius;

  modport source (
    output valid, corner0_x, corner0_y, corner1_x, corner1_y, corner2_x, corner2_y,
           corner3_x, corner3_y, circle_left, circle_top, circle_radius,
    input  ready
  );
  modport sink (
    input  valid, corner0_x, corner0_y, corner1_x, corner1_y, corner2_x, corner2_y,
           corner3_x, corner3_y, circle_left, circle_top, circle_radius,
    output ready
  );
endinterface

interface obbsat_rsp_if;
  import obbsat_pkg::*;
  logic                   valid;
  logic                   ready;
  logic                   hit;
  logic signed [NrmW-1:0] normal_x;
  logic signed [NrmW-1:0] normal_y;
  logic [DepthW-1:0]      depth;

  modport source (output valid, hit, normal_x, normal_y, depth, input ready);
  modport sink (input valid, hit, normal_x, normal_y, depth, output ready);
endinterface

### rtl/obbsat_mul.sv
`timescale 1ns / 1ps
module obbsat_mul (
  input  logic                                  clk_i,
  input  logic signed [obbsat_pkg::MulAW-1:0]   a_i,
  input  logic signed [obbsat_pkg::MulBW-1:0]   b_i,
  output logic signed [obbsat_pkg::MulPW-1:0]   p_o
);
  import obbsat_pkg::*;

  logic signed [MulPW-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= MulPW'(a_i) * MulPW'(b_i);
  end

  assign p_o = p_q;

endmodule

### rtl/obb_circle_sat_collision.sv
// Each axis that is tested runs a 32-step bit-serial square root and two 18-step dividers,
// then ten passes through the shared multiplier. Throughput: one request at a time; a new
// request is taken while the previous result waits on the output.
// Reset is asynchronous and active low; it empties the sequencer and the output register.
`timescale 1ns / 1ps
module obb_circle_sat_collision #(
  parameter int unsigned FRAC_BITS = obbsat_pkg::FracBitsDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  obbsat_req_if.sink   req_i,
  obbsat_rsp_if.source rsp_o
);
  import obbsat_pkg::*;

  localparam longint unsigned SkipSq = (64'd1 << (2 * FRAC_BITS)) / 64'd1000000000000;

  typedef enum logic [4:0] {
    S_IDLE, S_PREP, S_PREP2, S_AXIS, S_MAG, S_SKIP, S_NORM, S_SQ1, S_SQ2, S_SQ3,
    S_ROOT, S_DSET, S_DIV, S_SIGN, S_PROJ, S_EVAL1, S_EVAL2, S_EVAL3, S_EVAL4,
    S_NEXT, S_ORI1, S_ORI2, S_ORI3, S_DONE
  } state_e;

  state_e state_q;

  logic signed [CoordW-1:0] px_q [4];
  logic signed [CoordW-1:0] py_q [4];
  logic signed [CoordW-1:0] left_q, top_q;
  logic [RadW-1:0]          rad_q;
  logic signed [33:0]       ccx_q, ccy_q, sx01_q, sx23_q, sy01_q, sy23_q;
  logic signed [35:0]       dx_q, dy_q;
  logic [2:0]               idx_q;
  logic signed [34:0]       ax_q, ay_q;
  logic [33:0]              mx_q, my_q;
  logic                     sgx_q, sgy_q;
  logic [60:0]              sq_q;
  logic [61:0]              v_q;
  logic [62:0]              res_q, bit_q;
  logic [4:0]               cnt_q;
  logic                     comp_q;
  logic [30:0]              rem_q;
  logic [17:0]              nlo_q, q_q;
  logic signed [NrmW-1:0]   ux_q, uy_q, bx_q, by_q;
  logic [3:0]               pcnt_q;
  logic signed [55:0]       pacc_q, rmin_q, rmax_q, pc_q, cmin_q, cmax_q, hi_q, lo_q;
  logic signed [55:0]       d_q, best_q;
  logic                     have_q;
  logic                     r_hit_q;
  logic signed [NrmW-1:0]   r_nx_q, r_ny_q;
  logic [DepthW-1:0]        r_dep_q;
  logic                     out_valid_q, out_hit_q;
  logic signed [NrmW-1:0]   out_nx_q, out_ny_q;
  logic [DepthW-1:0]        out_dep_q;

  logic signed [MulAW-1:0]  mul_a;
  logic signed [MulBW-1:0]  mul_b;
  logic signed [MulPW-1:0]  mul_p;
  logic signed [55:0]       prod;
  logic [1:0]               ci, cn;
  logic signed [34:0]       ax_c, ay_c;
  logic [10:0]              sqs;
  logic                     skip;
  logic [33:0]              mmax;
  logic [62:0]              rb;
  logic                     rge;
  logic [29:0]              msel;
  logic [46:0]              nsum;
  logic [31:0]              rem2, remn;
  logic                     dge;
  logic signed [NrmW-1:0]   qs;
  logic [3:0]               pj;
  logic [2:0]               pt;
  logic signed [55:0]       psum, rad16;
  logic [56:0]              dsum;
  logic [40:0]              depc;

  obbsat_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  always_comb begin
    prod = mul_p[55:0];
    ci   = idx_q[1:0];
    cn   = ci + 2'd1;
    if (!idx_q[2]) begin
      ax_c = 35'(py_q[ci]) - 35'(py_q[cn]);
      ay_c = 35'(px_q[cn]) - 35'(px_q[ci]);
    end else begin
      ax_c = 35'(px_q[ci]) - 35'(ccx_q);
      ay_c = 35'(py_q[ci]) - 35'(ccy_q);
    end
    sqs  = ({6'b0, mx_q[4:0]} * {6'b0, mx_q[4:0]}) + ({6'b0, my_q[4:0]} * {6'b0, my_q[4:0]});
    skip = (mx_q < 34'd32) && (my_q < 34'd32) && (64'(sqs) <= SkipSq);
    mmax = (mx_q > my_q) ? mx_q : my_q;
    rb   = res_q + bit_q;
    rge  = {1'b0, v_q} >= rb;
    msel = comp_q ? my_q[29:0] : mx_q[29:0];
    nsum = {1'b0, msel, 16'b0} + 47'(res_q[30:1]);
    rem2 = {rem_q, nlo_q[17]};
    dge  = rem2 >= {1'b0, res_q[30:0]};
    remn = dge ? rem2 - {1'b0, res_q[30:0]} : rem2;
    qs   = $signed(q_q);
    pj   = pcnt_q - 4'd1;
    pt   = pcnt_q[3:1];
    psum = pacc_q + prod;
    rad16 = $signed({9'b0, rad_q, 16'b0});
    dsum = {1'b0, best_q} + 57'(32768);
    depc = dsum[56:16];
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      S_SQ1: begin
        mul_a = $signed({6'b0, mx_q[29:0]});
        mul_b = $signed({1'b0, mx_q[29:0]});
      end
      S_SQ2: begin
        mul_a = $signed({6'b0, my_q[29:0]});
        mul_b = $signed({1'b0, my_q[29:0]});
      end
      S_PROJ: begin
        if (pt == 3'd4) begin
          mul_a = pcnt_q[0] ? MulAW'(ccy_q) : MulAW'(ccx_q);
        end else begin
          mul_a = pcnt_q[0] ? MulAW'(py_q[pt[1:0]]) : MulAW'(px_q[pt[1:0]]);
        end
        mul_b = pcnt_q[0] ? MulBW'(uy_q) : MulBW'(ux_q);
      end
      S_ORI1: begin
        mul_a = dx_q;
        mul_b = MulBW'(bx_q);
      end
      S_ORI2: begin
        mul_a = dy_q;
        mul_b = MulBW'(by_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && rsp_o.ready && (state_q != S_DONE)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (req_i.valid) begin
            px_q[0] <= req_i.corner0_x;
            py_q[0] <= req_i.corner0_y;
            px_q[1] <= req_i.corner1_x;
            py_q[1] <= req_i.corner1_y;
            px_q[2] <= req_i.corner2_x;
            py_q[2] <= req_i.corner2_y;
            px_q[3] <= req_i.corner3_x;
            py_q[3] <= req_i.corner3_y;
            left_q  <= req_i.circle_left;
            top_q   <= req_i.circle_top;
            rad_q   <= req_i.circle_radius;
            state_q <= S_PREP;
          end
        end
        S_PREP: begin
          ccx_q   <= 34'(left_q) + $signed({3'b0, rad_q});
          ccy_q   <= 34'(top_q) + $signed({3'b0, rad_q});
          sx01_q  <= 34'(px_q[0]) + 34'(px_q[1]);
          sx23_q  <= 34'(px_q[2]) + 34'(px_q[3]);
          sy01_q  <= 34'(py_q[0]) + 34'(py_q[1]);
          sy23_q  <= 34'(py_q[2]) + 34'(py_q[3]);
          idx_q   <= '0;
          have_q  <= 1'b0;
          state_q <= S_PREP2;
        end
        S_PREP2: begin
          dx_q    <= (36'(ccx_q) <<< 2) - 36'(sx01_q) - 36'(sx23_q);
          dy_q    <= (36'(ccy_q) <<< 2) - 36'(sy01_q) - 36'(sy23_q);
          state_q <= S_AXIS;
        end
        S_AXIS: begin
          ax_q    <= ax_c;
          ay_q    <= ay_c;
          state_q <= S_MAG;
        end
        S_MAG: begin
          mx_q    <= ax_q[34] ? 34'(-ax_q) : 34'(ax_q);
          my_q    <= ay_q[34] ? 34'(-ay_q) : 34'(ay_q);
          sgx_q   <= ax_q[34];
          sgy_q   <= ay_q[34];
          state_q <= S_SKIP;
        end
        S_SKIP: begin
          state_q <= skip ? S_NEXT : S_NORM;
        end
        S_NORM: begin
          if (mmax[33:30] != '0) begin
            mx_q <= mx_q >> 1;
            my_q <= my_q >> 1;
          end else if (mmax[29:25] == '0) begin
            mx_q <= mx_q << 4;
            my_q <= my_q << 4;
          end else if (!mmax[29]) begin
            mx_q <= mx_q << 1;
            my_q <= my_q << 1;
          end else begin
            state_q <= S_SQ1;
          end
        end
        S_SQ1: begin
          state_q <= S_SQ2;
        end
        S_SQ2: begin
          sq_q    <= mul_p[60:0];
          state_q <= S_SQ3;
        end
        S_SQ3: begin
          v_q     <= {1'b0, sq_q} + {1'b0, mul_p[60:0]};
          res_q   <= '0;
          bit_q   <= 63'(1) << 62;
          cnt_q   <= '0;
          state_q <= S_ROOT;
        end
        S_ROOT: begin
          if (rge) begin
            v_q   <= v_q - rb[61:0];
            res_q <= (res_q >> 1) + bit_q;
          end else begin
            res_q <= res_q >> 1;
          end
          bit_q <= bit_q >> 2;
          cnt_q <= cnt_q + 5'd1;
          if (cnt_q == 5'd31) begin
            comp_q  <= 1'b0;
            state_q <= S_DSET;
          end
        end
        S_DSET: begin
          rem_q   <= {2'b0, nsum[46:18]};
          nlo_q   <= nsum[17:0];
          q_q     <= '0;
          cnt_q   <= '0;
          state_q <= S_DIV;
        end
        S_DIV: begin
          rem_q <= remn[30:0];
          nlo_q <= nlo_q << 1;
          q_q   <= {q_q[16:0], dge};
          cnt_q <= cnt_q + 5'd1;
          if (cnt_q == 5'd17) begin
            state_q <= S_SIGN;
          end
        end
        S_SIGN: begin
          if (!comp_q) begin
            ux_q    <= sgx_q ? -qs : qs;
            comp_q  <= 1'b1;
            state_q <= S_DSET;
          end else begin
            uy_q    <= sgy_q ? -qs : qs;
            pcnt_q  <= '0;
            state_q <= S_PROJ;
          end
        end
        S_PROJ: begin
          if (pcnt_q != '0) begin
            if (!pj[0]) begin
              pacc_q <= prod;
            end else if (pj[3:1] == 3'd4) begin
              pc_q <= psum;
            end else begin
              if (pj[3:1] == '0 || psum < rmin_q) begin
                rmin_q <= psum;
              end
              if (pj[3:1] == '0 || psum > rmax_q) begin
                rmax_q <= psum;
              end
            end
          end
          pcnt_q <= pcnt_q + 4'd1;
          if (pcnt_q == 4'd10) begin
            state_q <= S_EVAL1;
          end
        end
        S_EVAL1: begin
          cmin_q  <= pc_q - rad16;
          cmax_q  <= pc_q + rad16;
          state_q <= S_EVAL2;
        end
        S_EVAL2: begin
          if (rmax_q < cmin_q || cmax_q < rmin_q) begin
            r_hit_q <= 1'b0;
            r_nx_q  <= '0;
            r_ny_q  <= '0;
            r_dep_q <= '0;
            state_q <= S_DONE;
          end else begin
            hi_q    <= (rmax_q < cmax_q) ? rmax_q : cmax_q;
            lo_q    <= (rmin_q > cmin_q) ? rmin_q : cmin_q;
            state_q <= S_EVAL3;
          end
        end
        S_EVAL3: begin
          d_q     <= hi_q - lo_q;
          state_q <= S_EVAL4;
        end
        S_EVAL4: begin
          if (!have_q || d_q < best_q) begin
            have_q <= 1'b1;
            best_q <= d_q;
            bx_q   <= ux_q;
            by_q   <= uy_q;
          end
          state_q <= S_NEXT;
        end
        S_NEXT: begin
          if (idx_q != 3'd7) begin
            idx_q   <= idx_q + 3'd1;
            state_q <= S_AXIS;
          end else if (have_q) begin
            state_q <= S_ORI1;
          end else begin
            r_hit_q <= 1'b1;
            r_nx_q  <= '0;
            r_ny_q  <= '0;
            r_dep_q <= '1;
            state_q <= S_DONE;
          end
        end
        S_ORI1: begin
          state_q <= S_ORI2;
        end
        S_ORI2: begin
          pacc_q  <= prod;
          state_q <= S_ORI3;
        end
        S_ORI3: begin
          r_hit_q <= 1'b1;
          r_nx_q  <= psum[55] ? -bx_q : bx_q;
          r_ny_q  <= psum[55] ? -by_q : by_q;
          r_dep_q <= (depc[40:32] != '0) ? '1 : depc[31:0];
          state_q <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid_q || rsp_o.ready) begin
            out_valid_q <= 1'b1;
            out_hit_q   <= r_hit_q;
            out_nx_q    <= r_nx_q;
            out_ny_q    <= r_ny_q;
            out_dep_q   <= r_dep_q;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign req_i.ready    = (state_q == S_IDLE);
  assign rsp_o.valid    = out_valid_q;
  assign rsp_o.hit      = out_hit_q;
  assign rsp_o.normal_x = out_nx_q;
  assign rsp_o.normal_y = out_ny_q;
  assign rsp_o.depth    = out_dep_q;

endmodule

### rtl/obbsat_checker.sv
`timescale 1ns / 1ps
module obbsat_checker (
  input logic                                 clk_i,
  input logic                                 rst_ni,
  input logic                                 req_valid_i,
  input logic                                 req_ready_i,
  input logic                                 rsp_valid_i,
  input logic                                 rsp_ready_i,
  input logic                                 rsp_hit_i,
  input logic signed [obbsat_pkg::NrmW-1:0]   rsp_nx_i,
  input logic signed [obbsat_pkg::NrmW-1:0]   rsp_ny_i,
  input logic [obbsat_pkg::DepthW-1:0]        rsp_dep_i
);
  import obbsat_pkg::*;

  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("request taken while a request is in progress");

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_hit_i |-> rsp_nx_i == '0 && rsp_ny_i == '0 && rsp_dep_i == '0)
    else $error("miss carries nonzero normal or depth");

  a_no_axis: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_hit_i && rsp_nx_i == '0 && rsp_ny_i == '0 |-> rsp_dep_i == '1)
    else $error("hit with zero normal must report full depth");

  a_nrm_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_hit_i |-> rsp_nx_i >= -18'sd65536 && rsp_nx_i <= 18'sd65536 &&
                                 rsp_ny_i >= -18'sd65536 && rsp_ny_i <= 18'sd65536)
    else $error("normal out of unit range");

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_hit_i) &&
                                    $stable(rsp_nx_i) && $stable(rsp_ny_i) && $stable(rsp_dep_i))
    else $error("stalled result changed");

endmodule

bind obb_circle_sat_collision obbsat_checker u_obbsat_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_valid_i (req_i.valid),
  .req_ready_i (req_i.ready),
  .rsp_valid_i (rsp_o.valid),
  .rsp_ready_i (rsp_o.ready),
  .rsp_hit_i   (rsp_o.hit),
  .rsp_nx_i    (rsp_o.normal_x),
  .rsp_ny_i    (rsp_o.normal_y),
  .rsp_dep_i   (rsp_o.depth)
);
